// ----- rtl/bsws_pkg.sv -----
// Shared types and constants for the bounded stack with search.
// Holds the request and response word types, operation codes, cell control and FSM states.
// No dependencies.
package bsws_pkg;

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_PEEK   = 3'd2;
   localparam logic [2:0] OP_SEARCH = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [6:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               status;
      logic signed [31:0] data;
      logic [5:0]         found_index;
      logic [6:0]         count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   typedef struct packed {
      logic shift_down;
      logic shift_up;
      logic compare;
      logic scan_shift;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ----- rtl/bsws_cell.sv -----
// One stack cell: a stored word and a search hit flag, both shifted along the chain.
// Depends on bsws_pkg for the cell control type.
module bsws_cell
   import bsws_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [WORD_BITS-1:0] value,
   input  logic                 in_use,
   input  logic [WORD_BITS-1:0] up_data,
   input  logic [WORD_BITS-1:0] down_data,
   input  logic                 down_hit,
   output logic [WORD_BITS-1:0] data_ff,
   output logic                 hit_ff
);

   logic [WORD_BITS-1:0] data_in;
   logic                 hit_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_down) begin
         data_in = up_data;
      end else if (ctrl.shift_up) begin
         data_in = down_data;
      end
   end

   always_comb begin
      hit_in = hit_ff;
      if (ctrl.compare) begin
         hit_in = in_use && (data_ff == value);
      end else if (ctrl.scan_shift) begin
         hit_in = down_hit;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

endmodule

// ----- rtl/bounded_stack_with_search_core.sv -----
// Top level of the bounded stack with search: control FSM, count, capacity and the cell chain.
// Depends on bsws_pkg and bsws_cell.
//
// A start with busy low is accepted; unless it is a search on a non-empty stack, its result
// word appears in the next cycle on rsp_word with rsp_strobe high for exactly one cycle; the
// receiver cannot stall it. Push, pop, peek, clear and undefined operations never raise busy,
// so one word per cycle is sustained while no search scan holds busy high. Search compares
// every cell at once, then shifts the hit flags up the cell chain one position per cycle toward
// the top; a match ends the scan when its flag reaches the top cell, a miss once every stored
// entry has been passed, and busy is high while the scan runs.
module bounded_stack_with_search_core
   import bsws_pkg::*;
#(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_word,
   output logic       rsp_strobe,
   output rsp_type    rsp_word,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [6:0]       capacity_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff, rsp_in;

   cell_ctrl_type        ctrl;
   logic [WORD_BITS-1:0] word;
   logic [63:0]          value_ext;
   logic [63:0]          top_ext;
   logic [CMP_W-1:0]     cap_eff;
   logic [CMP_W-1:0]     count_ext;
   logic [CMP_W-1:0]     count_next_ext;
   logic [CMP_W-1:0]     found_pos;
   logic                 accept;
   logic                 can_push;
   logic                 can_pop;

   logic [WORD_BITS-1:0] cell_data [DEPTH];
   logic                 cell_hit  [DEPTH];

   assign value_ext = {32'b0, req_word.value};
   assign word      = value_ext[WORD_BITS-1:0];
   assign top_ext   = 64'(cell_data[0]);
   assign accept    = start && (state_ff == ST_IDLE);

   always_comb begin
      cap_eff = CMP_W'(capacity_ff);
      if (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end
   end

   assign count_ext = CMP_W'(count_ff);
   assign can_push  = count_ext < cap_eff;
   assign can_pop   = count_ff != '0;
   assign found_pos = CMP_W'(count_ff) - CMP_W'(1) - CMP_W'(scan_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.operation == OP_SEARCH) && can_pop) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cell_hit[0] || (scan_ff + CNT_W'(1) == count_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rsp_in        = rsp_ff;
      rsp_in.status = 1'b1;
      rsp_in.data   = '0;
      rsp_in.found_index = '0;
      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (accept) begin
               case (req_word.operation)
                  OP_PUSH: begin
                     if (can_push) begin
                        ctrl.shift_down = 1'b1;
                        count_in        = count_ff + CNT_W'(1);
                        rsp_in.status   = 1'b0;
                     end
                  end
                  OP_POP: begin
                     if (can_pop) begin
                        ctrl.shift_up = 1'b1;
                        count_in      = count_ff - CNT_W'(1);
                        rsp_in.status = 1'b0;
                        rsp_in.data   = top_ext[31:0];
                     end
                  end
                  OP_PEEK: begin
                     if (can_pop) begin
                        rsp_in.status = 1'b0;
                        rsp_in.data   = top_ext[31:0];
                     end
                  end
                  OP_SEARCH: begin
                     ctrl.compare = 1'b1;
                  end
                  OP_CLEAR: begin
                     count_in      = '0;
                     rsp_in.status = 1'b0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cell_hit[0]) begin
               rsp_in.status      = 1'b0;
               rsp_in.found_index = found_pos[5:0];
            end else begin
               ctrl.scan_shift = 1'b1;
               scan_in         = scan_ff + CNT_W'(1);
            end
         end
         default: begin
            scan_in = '0;
         end
      endcase
      count_next_ext  = CMP_W'(count_in);
      rsp_in.count    = count_next_ext[6:0];
      rsp_in.is_empty = count_in == '0;
      rsp_in.is_full  = count_next_ext >= cap_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         capacity_ff   <= CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         rsp_strobe_ff <= (accept && !(req_word.operation == OP_SEARCH && can_pop))
                          || ((state_ff == ST_SCAN) && (state_in == ST_IDLE));
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [WORD_BITS-1:0] up_data;
      logic [WORD_BITS-1:0] down_data;
      logic                 down_hit;
      logic                 in_use;

      assign in_use = count_ff > CNT_W'(k);

      if (k == 0) begin : g_top
         assign up_data = word;
      end else begin : g_mid
         assign up_data = cell_data[k-1];
      end

      if (k == DEPTH - 1) begin : g_bottom
         assign down_data = '0;
         assign down_hit  = 1'b0;
      end else begin : g_inner
         assign down_data = cell_data[k+1];
         assign down_hit  = cell_hit[k+1];
      end

      bsws_cell #(
         .WORD_BITS(WORD_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .value    (word),
         .in_use   (in_use),
         .up_data  (up_data),
         .down_data(down_data),
         .down_hit (down_hit),
         .data_ff  (cell_data[k]),
         .hit_ff   (cell_hit[k])
      );
   end

   assign busy       = state_ff == ST_SCAN;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("Entry count exceeds the built depth.");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0) && (scan_ff < count_ff))
      else $error("Search scan ran past the stored entries.");

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.operation != OP_SEARCH)) |=> rsp_strobe)
      else $error("Missing result word one cycle after a non-search operation.");

   a_scan_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (state_in == ST_IDLE)) |=> rsp_strobe && !busy)
      else $error("Search finished without a result word.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.is_empty == (rsp_word.count == 7'd0)))
      else $error("Empty flag disagrees with the count.");

endmodule

// ----- verif/tb_bounded_stack_with_search_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bounded_stack_with_search_core: directed, capacity and random tests
// against an in-bench stack predictor. Depends on bsws_pkg and the core RTL.
module tb_bounded_stack_with_search_core;
   import bsws_pkg::*;

   localparam int DEPTH = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PRINT_LIMIT = 100;
   localparam logic [2:0] OP_BAD_FIRST = 3'd5;
   localparam logic [2:0] OP_BAD_LAST = 3'd7;
   localparam logic [31:0] WORD_MIN = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_word = '0;
   logic rsp_strobe;
   rsp_type rsp_word;
   logic csr_we = 1'b0;
   logic [6:0] csr_wdata = '0;

   logic [31:0] stack_words [DEPTH];
   int stack_count = 0;
   logic [6:0] stack_capacity = CAP_RESET;
   rsp_type pending_rsp [$];
   int error_count = 0;
   int quiet_cycles = 0;
   bit use_gaps = 1'b1;

   bounded_stack_with_search_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type predict_result(input req_type r);
      rsp_type res;
      int limit;
      res = '0;
      res.status = 1'b1;
      limit = (stack_capacity > DEPTH) ? DEPTH : int'(stack_capacity);
      case (r.operation)
         OP_PUSH: begin
            if (stack_count < limit) begin
               stack_words[stack_count] = r.value;
               stack_count++;
               res.status = 1'b0;
            end
         end
         OP_POP: begin
            if (stack_count > 0) begin
               stack_count--;
               res.data = stack_words[stack_count];
               res.status = 1'b0;
            end
         end
         OP_PEEK: begin
            if (stack_count > 0) begin
               res.data = stack_words[stack_count - 1];
               res.status = 1'b0;
            end
         end
         OP_SEARCH: begin
            for (int i = stack_count - 1; i >= 0; i--) begin
               if (stack_words[i] == r.value) begin
                  res.found_index = 6'(i);
                  res.status = 1'b0;
                  break;
               end
            end
         end
         OP_CLEAR: begin
            stack_count = 0;
            res.status = 1'b0;
         end
         default: begin
         end
      endcase
      res.count = 7'(stack_count);
      res.is_empty = (stack_count == 0);
      res.is_full = (stack_count >= limit);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result word with nothing pending");
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", 32'(rsp_word.status), 32'(want.status));
            check_field("data", rsp_word.data, want.data);
            check_field("found_index", 32'(rsp_word.found_index), 32'(want.found_index));
            check_field("count", 32'(rsp_word.count), 32'(want.count));
            check_field("is_empty", 32'(rsp_word.is_empty), 32'(want.is_empty));
            check_field("is_full", 32'(rsp_word.is_full), 32'(want.is_full));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("bounded_stack_with_search_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [2:0] op, input logic [31:0] val);
      req_type r;
      int gap;
      r.operation = op;
      r.value = val;
      if (use_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_result(r));
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] cap);
      wait_until_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(negedge clock);
      csr_we <= 1'b0;
      stack_capacity = cap;
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] pool [8];
      pool = '{32'd0, WORD_ONES, WORD_MIN, WORD_MAX, 32'd1, 32'd2, 32'h5555_5555,
               32'hAAAA_AAAA};
      if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_operation(input bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 50 : 15)) return OP_PUSH;
      if (roll < 65) return OP_POP;
      if (roll < 75) return OP_PEEK;
      if (roll < 94) return OP_SEARCH;
      if (roll < 96) return OP_CLEAR;
      return 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
   endfunction

   task automatic run_random_phase(input int n_items);
      logic [2:0] op;
      logic [31:0] val;
      for (int k = 0; k < n_items; k++) begin
         op = pick_operation((k / 40) % 2 == 0);
         if (op == OP_SEARCH && stack_count > 0 && $urandom_range(0, 2) != 0)
            val = stack_words[$urandom_range(0, stack_count - 1)];
         else
            val = pick_value();
         send_word(op, val);
      end
   endtask

   task automatic test_basic_ops();
      send_word(OP_POP, 32'd0);
      send_word(OP_PEEK, 32'd0);
      send_word(OP_SEARCH, 32'd0);
      send_word(OP_PUSH, WORD_MIN);
      send_word(OP_PUSH, WORD_MAX);
      send_word(OP_PUSH, 32'd0);
      send_word(OP_PUSH, WORD_ONES);
      send_word(OP_PUSH, WORD_MAX);
      send_word(OP_SEARCH, WORD_MAX);
      send_word(OP_SEARCH, WORD_MIN);
      send_word(OP_SEARCH, 32'h0001_2345);
      send_word(OP_PEEK, 32'd0);
      for (logic [3:0] op = 4'(OP_BAD_FIRST); op <= 4'(OP_BAD_LAST); op++) begin
         send_word(op[2:0], $urandom);
      end
      send_word(OP_POP, 32'd0);
      send_word(OP_POP, 32'd0);
      send_word(OP_CLEAR, 32'd0);
      send_word(OP_PEEK, 32'd0);
      send_word(OP_SEARCH, WORD_MIN);
      send_word(OP_PUSH, 32'd7);
      send_word(OP_CLEAR, WORD_ONES);
   endtask

   task automatic test_capacity_limits();
      write_capacity(7'd2);
      send_word(OP_PUSH, 32'd10);
      send_word(OP_PUSH, 32'd11);
      send_word(OP_PUSH, 32'd12);
      send_word(OP_SEARCH, 32'd10);
      write_capacity(7'd1);
      send_word(OP_PUSH, 32'd13);
      send_word(OP_PEEK, 32'd0);
      send_word(OP_POP, 32'd0);
      send_word(OP_PUSH, 32'd14);
      send_word(OP_POP, 32'd0);
      send_word(OP_POP, 32'd0);
      send_word(OP_PUSH, 32'd15);
      send_word(OP_PUSH, 32'd16);
      write_capacity(7'd0);
      send_word(OP_PUSH, 32'd17);
      send_word(OP_SEARCH, 32'd15);
      send_word(OP_POP, 32'd0);
      send_word(OP_PUSH, 32'd18);
      send_word(OP_PEEK, 32'd0);
   endtask

   task automatic test_full_depth();
      write_capacity(7'd127);
      send_word(OP_CLEAR, 32'd0);
      repeat (DEPTH + 1) send_word(OP_PUSH, pick_value());
      send_word(OP_SEARCH, stack_words[0]);
      send_word(OP_SEARCH, stack_words[DEPTH - 1]);
      send_word(OP_SEARCH, stack_words[$urandom_range(1, DEPTH - 2)]);
      send_word(OP_SEARCH, $urandom);
      repeat (DEPTH + 1) send_word(OP_POP, 32'd0);
      write_capacity(CAP_RESET);
   endtask

   task automatic test_random_traffic();
      run_random_phase(300);
      write_capacity(7'd5);
      run_random_phase(150);
      write_capacity(7'd127);
      run_random_phase(300);
      write_capacity(7'd0);
      run_random_phase(40);
      write_capacity(7'($urandom_range(1, 63)));
      run_random_phase(200);
   endtask

   task automatic test_back_to_back();
      write_capacity(CAP_RESET);
      use_gaps = 1'b0;
      run_random_phase(200);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_capacity_limits();
      test_full_depth();
      test_random_traffic();
      test_back_to_back();
      wait_until_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("bounded_stack_with_search_core test passed");
      end else begin
         $display("bounded_stack_with_search_core test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bsws_pkg.sv
rtl/bsws_cell.sv
rtl/bounded_stack_with_search_core.sv
verif/tb_bounded_stack_with_search_core.sv
